@@ rtl/rirr_pkg.sv @@
// ----------------------------------------------------------------------------
// rirr_pkg
// Shared constants and codes for the reuse-interval RRIP replacement block.
// ----------------------------------------------------------------------------
package rirr_pkg;

    localparam int STAMP_W = 32;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 16;
    localparam int PC_W    = 16;
    localparam int SETI_W  = 11;
    localparam int WAYI_W  = 4;

    localparam int ADDR_W  = 4;

    typedef enum logic [1:0] {
        MODE_VICTIM = 2'd0,
        MODE_HIT    = 2'd1,
        MODE_FILL   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    localparam logic [ADDR_W-1:0] ADDR_SHORT = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_MOD   = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_CONF  = 4'h8;

endpackage

@@ rtl/rirr_ram.sv @@
// ----------------------------------------------------------------------------
// rirr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rirr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rirr_sigrem.sv @@
// ----------------------------------------------------------------------------
// rirr_sigrem
// Remainder of a PC value by the signature table depth through a reciprocal
// multiply, with the quotient registered before the remainder is formed.
// ----------------------------------------------------------------------------
module rirr_sigrem #(
    parameter int SIG_ENTRIES = 32768
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rirr_pkg::PC_W-1:0]      value,
    output logic                           done,
    output logic [$clog2(SIG_ENTRIES)-1:0] rem
);

    localparam int SIG_W   = $clog2(SIG_ENTRIES);
    localparam int PC_W    = rirr_pkg::PC_W;
    localparam int RECIP_W = PC_W + 1;
    localparam int SHIFT   = PC_W + SIG_W;
    localparam int PROD_W  = PC_W + RECIP_W;
    // Rounded-up reciprocal of the depth; with this shift the quotient is
    // exact for every PC value.
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(SIG_ENTRIES) - 64'd1) / 64'(SIG_ENTRIES);

    logic [PROD_W-1:0] prod;
    logic [PC_W-1:0]   quot;
    logic [PC_W-1:0]   back;
    logic [PC_W-1:0]   value_reg;
    logic [PC_W-1:0]   quot_reg;
    logic [SIG_W-1:0]  rem_reg;
    logic              busy_reg;
    logic              done_reg;

    // Quotient from the multiply by the reciprocal, registered on start.
    assign prod = value * RECIP_W'(RECIP);
    assign quot = PC_W'(prod >> SHIFT);

    // Remainder as the value minus the registered quotient times depth.
    assign back = PC_W'(quot_reg * RECIP_W'(SIG_ENTRIES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg && !start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            value_reg <= value;
            quot_reg  <= quot;
        end
        if (busy_reg)
        begin
            rem_reg <= SIG_W'(value_reg - back);
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/rirr_victim.sv @@
// ----------------------------------------------------------------------------
// rirr_victim
// Victim selection and set ageing over one row of way ages.
// ----------------------------------------------------------------------------
module rirr_victim #(
    parameter int NUM_WAYS = 16,
    parameter int AGE_BITS = 2
) (
    input  logic [NUM_WAYS*AGE_BITS-1:0] ages,
    output logic [$clog2(NUM_WAYS)-1:0]  pick,
    output logic [NUM_WAYS*AGE_BITS-1:0] aged
);

    localparam int WAY_W   = $clog2(NUM_WAYS);
    localparam int NUM_AGE = 1 << AGE_BITS;

    logic [NUM_AGE-1:0]  present;
    logic [AGE_BITS-1:0] oldest;
    logic [AGE_BITS-1:0] gap;

    // Mark every age value that occurs somewhere in the set.
    always_comb
    begin
        present = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            present[ages[w*AGE_BITS +: AGE_BITS]] = 1'b1;
        end
    end

    always_comb
    begin
        oldest = '0;
        for (int a = 0; a < NUM_AGE; a++)
        begin
            if (present[a])
            begin
                oldest = AGE_BITS'(a);
            end
        end
    end

    // The lowest way at the oldest age is the victim, once the set is aged.
    always_comb
    begin
        pick = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (ages[w*AGE_BITS +: AGE_BITS] == oldest)
            begin
                pick = WAY_W'(w);
            end
        end
    end

    assign gap = ~oldest;

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            aged[w*AGE_BITS +: AGE_BITS] = ages[w*AGE_BITS +: AGE_BITS] + gap;
        end
    end

endmodule

@@ rtl/reuse_interval_rrip_replacement.sv @@
// ----------------------------------------------------------------------------
// reuse_interval_rrip_replacement
// RRIP replacement policy with a per-signature reuse-interval predictor.
// ----------------------------------------------------------------------------
// One event at a time. Victim or hit: row read and write-back, then signature update
// (RD, LINE, SIG, FIN). Fill: signature remainder (REM), row and signature reads (RD, LINE),
// row write with the insertion age (MUL, FIN); a fill writes no signature entry.
// Ignored event: straight to the result (FIN); a stalled result holds input.
// After reset a clearing pass walks max(NUM_SETS, SIG_ENTRIES) addresses of both memories
// (32768 by default); no beat is accepted during it, configuration writes are.
// ----------------------------------------------------------------------------
module reuse_interval_rrip_replacement #(
    parameter int NUM_SETS    = 2048,
    parameter int NUM_WAYS    = 16,
    parameter int SIG_ENTRIES = 32768,
    parameter int AGE_BITS    = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input beat.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // set_index, way_index, pc_low, zero pad
    input  logic [1:0]                    s_tuser,  // mode
    // Result beat.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // victim_way, zero pad
    output logic                          m_tuser,  // victim_valid
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rirr_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int SET_AW  = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W   = $clog2(NUM_WAYS);
    localparam int SIG_W   = $clog2(SIG_ENTRIES);
    localparam int STAMP_W = rirr_pkg::STAMP_W;
    localparam int SUM_W   = rirr_pkg::SUM_W;
    localparam int CNT_W   = rirr_pkg::CNT_W;
    localparam int SIGM_W  = SUM_W + CNT_W;
    // Per-line entry: {stamp, signature, reused, age}.
    localparam int E_W     = AGE_BITS + 1 + SIG_W + STAMP_W;
    localparam int ROW_W   = NUM_WAYS * E_W;
    localparam int SG_LO   = AGE_BITS + 1;
    localparam int ST_LO   = AGE_BITS + 1 + SIG_W;
    localparam int CLR_DEPTH = NUM_SETS > SIG_ENTRIES ? NUM_SETS : SIG_ENTRIES;
    localparam int CLR_W   = $clog2(CLR_DEPTH);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_REM   = 8'b0000_0100,
        ST_RD    = 8'b0000_1000,
        ST_LINE  = 8'b0001_0000,
        ST_SIG   = 8'b0010_0000,
        ST_MUL   = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    // Input beat fields.
    logic [rirr_pkg::SETI_W-1:0] in_set;
    logic [rirr_pkg::WAYI_W-1:0] in_way;
    logic [rirr_pkg::PC_W-1:0]   in_pc;
    logic                        in_accept;
    logic                        set_ok;
    logic                        way_ok;

    assign in_set = s_tdata[10:0];
    assign in_way = s_tdata[14:11];
    assign in_pc  = s_tdata[30:15];

    state_t                      state_reg, state_next;
    rirr_pkg::mode_t             mode_reg;
    logic [SET_AW-1:0]           set_reg;
    logic [WAY_W-1:0]            way_reg;
    logic [SIG_W-1:0]            sig_reg, sig_next;
    logic                        reused_reg, reused_next;
    logic [ROW_W-1:0]            row_reg, row_next;
    logic [STAMP_W-1:0]          acc_reg, acc_next;
    logic [STAMP_W-1:0]          interval_reg, interval_next;
    logic [SUM_W-1:0]            prod_s_reg, prod_m_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CLR_W-1:0]            clr_reg;
    logic [3:0]                  res_way_reg, res_way_next;
    logic                        res_vld_reg, res_vld_next;
    logic                        m_valid_reg;
    logic [3:0]                  m_way_reg;
    logic                        m_vld_reg;
    logic [31:0]                 short_lim_reg;
    logic [31:0]                 mod_lim_reg;
    logic [CNT_W-1:0]            conf_reg;

    // Memory ports.
    logic                        row_we, row_re;
    logic [SET_AW-1:0]           row_waddr, row_raddr;
    logic [ROW_W-1:0]            row_wdata, row_q, row_clear;
    logic                        sig_we, sig_re;
    logic [SIG_W-1:0]            sig_waddr, sig_raddr;
    logic [SIGM_W-1:0]           sig_wdata, sig_q;

    // Helper values.
    logic [NUM_WAYS*AGE_BITS-1:0] ages, aged;
    logic [WAY_W-1:0]            vpick;
    logic [E_W-1:0]              ent, vent;
    logic [SUM_W-1:0]            q_sum;
    logic [CNT_W-1:0]            q_cnt;
    logic [SUM_W:0]              sum_add;
    logic [STAMP_W-1:0]          acc_inc;
    logic                        rem_start, rem_done;
    logic [SIG_W-1:0]            rem_val;
    logic [AGE_BITS-1:0]         ins_age;

    assign set_ok    = 32'(in_set) < 32'(NUM_SETS);
    assign way_ok    = 32'(in_way) < 32'(NUM_WAYS);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign rem_start = in_accept && set_ok && (rirr_pkg::mode_t'(s_tuser) == rirr_pkg::MODE_FILL)
                       && way_ok;

    assign q_sum   = sig_q[SIGM_W-1:CNT_W];
    assign q_cnt   = sig_q[CNT_W-1:0];
    assign acc_inc = acc_reg + 1'b1;
    assign ent     = row_q[way_reg*E_W +: E_W];
    assign vent    = row_q[vpick*E_W +: E_W];
    // Hit update of the interval sum; the carry out marks saturation.
    assign sum_add = {1'b0, q_sum} + (SUM_W+1)'(interval_reg);

    // Reset image of one set row: ages at maximum, everything else zero.
    always_comb
    begin
        row_clear = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            row_clear[w*E_W +: AGE_BITS] = '1;
        end
    end

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            ages[w*AGE_BITS +: AGE_BITS] = row_q[w*E_W +: AGE_BITS];
        end
    end

    rirr_victim #(
        .NUM_WAYS (NUM_WAYS),
        .AGE_BITS (AGE_BITS)
    ) u_victim (
        .ages (ages),
        .pick (vpick),
        .aged (aged)
    );

    rirr_sigrem #(
        .SIG_ENTRIES (SIG_ENTRIES)
    ) u_sigrem (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rem_start),
        .value (in_pc),
        .done  (rem_done),
        .rem   (rem_val)
    );

    rirr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_q)
    );

    rirr_ram #(
        .WIDTH (SIGM_W),
        .DEPTH (SIG_ENTRIES)
    ) u_sig_ram (
        .clk   (clk),
        .we    (sig_we),
        .waddr (sig_waddr),
        .wdata (sig_wdata),
        .re    (sig_re),
        .raddr (sig_raddr),
        .rdata (sig_q)
    );

    // Fill insertion age from the registered products of limit and count.
    always_comb
    begin
        ins_age = '1;
        if (cnt_reg >= conf_reg)
        begin
            if (sum_reg < prod_s_reg)
            begin
                ins_age = '0;
            end
            else if (sum_reg < prod_m_reg)
            begin
                ins_age = '1 - 1'b1;
            end
        end
    end

    // Main sequencer: reads a set row and updates it; a victim or hit then updates the
    // signature entry that the event refers to, a fill only reads that entry with the row.
    always_comb
    begin
        state_next    = state_reg;
        sig_next      = sig_reg;
        reused_next   = reused_reg;
        row_next      = row_reg;
        acc_next      = acc_reg;
        interval_next = interval_reg;
        res_way_next  = res_way_reg;
        res_vld_next  = res_vld_reg;
        row_we        = 1'b0;
        row_re        = 1'b0;
        row_waddr     = set_reg;
        row_raddr     = set_reg;
        row_wdata     = row_reg;
        sig_we        = 1'b0;
        sig_re        = 1'b0;
        sig_waddr     = sig_reg;
        sig_raddr     = sig_reg;
        sig_wdata     = {sum_reg, cnt_reg};

        unique case (state_reg)
            ST_CLEAR:
            begin
                row_waddr = clr_reg[SET_AW-1:0];
                row_wdata = row_clear;
                row_we    = {1'b0, clr_reg} < (CLR_W+1)'(NUM_SETS);
                sig_waddr = clr_reg[SIG_W-1:0];
                sig_wdata = '0;
                sig_we    = {1'b0, clr_reg} < (CLR_W+1)'(SIG_ENTRIES);
                if ({1'b0, clr_reg} == (CLR_W+1)'(CLR_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_way_next = '0;
                    res_vld_next = 1'b0;
                    if (!set_ok || rirr_pkg::mode_t'(s_tuser) == rirr_pkg::MODE_NONE)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (rirr_pkg::mode_t'(s_tuser) == rirr_pkg::MODE_VICTIM)
                    begin
                        state_next = ST_RD;
                    end
                    else if (!way_ok)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (rirr_pkg::mode_t'(s_tuser) == rirr_pkg::MODE_FILL)
                    begin
                        state_next = ST_REM;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_REM:
            begin
                if (rem_done)
                begin
                    sig_next   = rem_val;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                row_re = 1'b1;
                sig_re = (mode_reg == rirr_pkg::MODE_FILL);
                state_next = ST_LINE;
            end
            ST_LINE:
            begin
                row_next = row_q;
                unique case (mode_reg)
                    rirr_pkg::MODE_VICTIM:
                    begin
                        for (int w = 0; w < NUM_WAYS; w++)
                        begin
                            row_next[w*E_W +: AGE_BITS] = aged[w*AGE_BITS +: AGE_BITS];
                        end
                        row_next[vpick*E_W + AGE_BITS +: E_W - AGE_BITS] = '0;
                        row_we       = 1'b1;
                        row_wdata    = row_next;
                        sig_next     = vent[SG_LO +: SIG_W];
                        reused_next  = vent[AGE_BITS];
                        sig_re       = 1'b1;
                        sig_raddr    = vent[SG_LO +: SIG_W];
                        res_way_next = 4'(vpick);
                        res_vld_next = 1'b1;
                        state_next   = ST_SIG;
                    end
                    rirr_pkg::MODE_HIT:
                    begin
                        acc_next      = acc_inc;
                        interval_next = acc_inc - ent[ST_LO +: STAMP_W];
                        sig_next      = ent[SG_LO +: SIG_W];
                        row_next[way_reg*E_W +: E_W] =
                            {acc_inc, ent[SG_LO +: SIG_W], 1'b1, AGE_BITS'(0)};
                        row_we        = 1'b1;
                        row_wdata     = row_next;
                        sig_re        = 1'b1;
                        sig_raddr     = ent[SG_LO +: SIG_W];
                        state_next    = ST_SIG;
                    end
                    rirr_pkg::MODE_FILL:
                    begin
                        acc_next = acc_inc;
                        row_next[way_reg*E_W +: E_W] =
                            {acc_inc, sig_reg, 1'b0, ent[AGE_BITS-1:0]};
                        state_next = ST_MUL;
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_MUL:
            begin
                row_next[way_reg*E_W +: AGE_BITS] = ins_age;
                row_we     = 1'b1;
                row_wdata  = row_next;
                state_next = ST_FIN;
            end
            ST_SIG:
            begin
                if (mode_reg == rirr_pkg::MODE_VICTIM)
                begin
                    sig_wdata = {q_sum, q_cnt - 1'b1};
                    sig_we    = !reused_reg && (q_cnt != '0);
                end
                else
                begin
                    sig_wdata = {sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0],
                                 (q_cnt == {CNT_W{1'b1}}) ? q_cnt : q_cnt + 1'b1};
                    sig_we    = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            acc_reg       <= '0;
            m_valid_reg   <= 1'b0;
            short_lim_reg <= 32'd25000;
            mod_lim_reg   <= 32'd50000;
            conf_reg      <= CNT_W'(2);
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ST_FIN && (!m_valid_reg || m_tready))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (psel && penable && pwrite)
            begin
                unique case (paddr)
                    rirr_pkg::ADDR_SHORT: short_lim_reg <= pwdata;
                    rirr_pkg::ADDR_MOD:   mod_lim_reg   <= pwdata;
                    rirr_pkg::ADDR_CONF:  conf_reg      <= pwdata[CNT_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg <= rirr_pkg::mode_t'(s_tuser);
            set_reg  <= SET_AW'(in_set);
            way_reg  <= WAY_W'(in_way);
        end
        sig_reg      <= sig_next;
        reused_reg   <= reused_next;
        row_reg      <= row_next;
        interval_reg <= interval_next;
        res_way_reg  <= res_way_next;
        res_vld_reg  <= res_vld_next;
        if (state_reg == ST_LINE)
        begin
            sum_reg    <= (mode_reg == rirr_pkg::MODE_FILL) ? q_sum : sum_reg;
            cnt_reg    <= q_cnt;
            prod_s_reg <= SUM_W'(short_lim_reg * q_cnt);
            prod_m_reg <= SUM_W'(mod_lim_reg * q_cnt);
        end
        if (state_reg == ST_FIN && (!m_valid_reg || m_tready))
        begin
            m_way_reg <= res_way_reg;
            m_vld_reg <= res_vld_reg;
        end
    end

    // Configuration reads.
    always_comb
    begin
        unique case (paddr)
            rirr_pkg::ADDR_SHORT: prdata = short_lim_reg;
            rirr_pkg::ADDR_MOD:   prdata = mod_lim_reg;
            rirr_pkg::ADDR_CONF:  prdata = 32'(conf_reg);
            default:              prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_way_reg};
    assign m_tuser  = m_vld_reg;

endmodule

@@ tb/sv/tb_reuse_interval_rrip_replacement.sv @@
// ----------------------------------------------------------------------------
// tb_reuse_interval_rrip_replacement
// Self-checking bench for the reuse-interval RRIP replacement block: a
// behavioral copy of the policy predicts every result beat, which is compared
// field by field as the beats leave the block under random flow control.
// ----------------------------------------------------------------------------
module tb_reuse_interval_rrip_replacement;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETS      = 2048;
    localparam int WAYS      = 16;
    localparam int SIGS      = 32768;
    localparam int LINES     = SETS * WAYS;
    localparam int AGE_TOP   = 3;
    localparam int MAX_CYCLE = 3000000;
    localparam int DRAIN     = 32;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [rirr_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    reuse_interval_rrip_replacement u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Expected result beats, oldest first: {victim_valid, victim_way}.
    logic [4:0] victim_queue[$];

    // Behavioral copy of the replacement state and its registers.
    bit [1:0]  age_mem[LINES];
    bit        reused_mem[LINES];
    bit [14:0] sig_mem[LINES];
    bit [31:0] stamp_mem[LINES];
    bit [47:0] sum_mem[SIGS];
    bit [15:0] count_mem[SIGS];
    bit [31:0] access_ctr;
    bit [31:0] short_limit;
    bit [31:0] moderate_limit;
    bit [15:0] conf_min;

    int  send_idle_pct;
    int  stall_pct;
    int  cycle_count = 0;
    bit  failed = 1'b0;

    // Work out one event's effect on the state and the beat it produces.
    function automatic logic [4:0] replace_predict(rirr_pkg::mode_t mode, bit [10:0] set_idx,
                                                   bit [3:0] way, bit [15:0] pc);
        int        base;
        int        idx;
        int        oldest;
        int        pick;
        bit [14:0] sig;
        bit [31:0] interval;
        bit [48:0] total;
        bit [63:0] cnt;
        bit [1:0]  ins_age;
        base = set_idx * WAYS;
        if (mode == rirr_pkg::MODE_VICTIM)
        begin
            oldest = 0;
            pick = 0;
            for (int w = 0; w < WAYS; w++)
            begin
                if (int'(age_mem[base + w]) > oldest)
                begin
                    oldest = int'(age_mem[base + w]);
                    pick = w;
                end
            end
            // Age the whole set until some way reaches the top.
            for (int w = 0; w < WAYS; w++)
            begin
                age_mem[base + w] = 2'(int'(age_mem[base + w]) + AGE_TOP - oldest);
            end
            idx = base + pick;
            sig = sig_mem[idx];
            // A line evicted without reuse weakens its signature.
            if (!reused_mem[idx] && count_mem[sig] != 16'd0)
            begin
                count_mem[sig] = count_mem[sig] - 16'd1;
            end
            reused_mem[idx] = 1'b0;
            sig_mem[idx] = '0;
            stamp_mem[idx] = '0;
            return {1'b1, pick[3:0]};
        end
        if (mode == rirr_pkg::MODE_NONE)
        begin
            return 5'd0;
        end
        idx = base + way;
        access_ctr = access_ctr + 32'd1;
        if (mode == rirr_pkg::MODE_HIT)
        begin
            interval = access_ctr - stamp_mem[idx];
            sig = sig_mem[idx];
            age_mem[idx] = 2'd0;
            reused_mem[idx] = 1'b1;
            total = {1'b0, sum_mem[sig]} + {17'd0, interval};
            sum_mem[sig] = total[48] ? 48'hFFFF_FFFF_FFFF : total[47:0];
            if (count_mem[sig] != 16'hFFFF)
            begin
                count_mem[sig] = count_mem[sig] + 16'd1;
            end
            stamp_mem[idx] = access_ctr;
        end
        else
        begin
            sig = pc[14:0];
            sig_mem[idx] = sig;
            reused_mem[idx] = 1'b0;
            stamp_mem[idx] = access_ctr;
            cnt = 64'(count_mem[sig]);
            ins_age = 2'(AGE_TOP);
            // Compare the average against the limits without dividing.
            if (cnt >= 64'(conf_min))
            begin
                if (64'(sum_mem[sig]) < 64'(short_limit) * cnt)
                begin
                    ins_age = 2'd0;
                end
                else if (64'(sum_mem[sig]) < 64'(moderate_limit) * cnt)
                begin
                    ins_age = 2'(AGE_TOP - 1);
                end
            end
            age_mem[idx] = ins_age;
        end
        return 5'd0;
    endfunction

    // Drive one event and wait for its acceptance; the sender may idle first.
    task automatic send_event(rirr_pkg::mode_t mode, bit [10:0] set_idx, bit [3:0] way,
                              bit [15:0] pc);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, pc, way, set_idx};
        // Sample the ready at the falling edge, where it is stable.
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        victim_queue.push_back(replace_predict(mode, set_idx, way, pc));
    endtask

    // Lower valid and wait until every expected beat is out, then let the
    // block settle before anything touches its registers.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (victim_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic [rirr_pkg::ADDR_W-1:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            rirr_pkg::ADDR_SHORT: short_limit    = value;
            rirr_pkg::ADDR_MOD:   moderate_limit = value;
            default:              conf_min       = value[15:0];
        endcase
    endtask

    task automatic set_limits(logic [31:0] short_v, logic [31:0] mod_v, logic [15:0] conf_v);
        wait_idle();
        write_reg(rirr_pkg::ADDR_SHORT, short_v);
        write_reg(rirr_pkg::ADDR_MOD, mod_v);
        write_reg(rirr_pkg::ADDR_CONF, {16'd0, conf_v});
    endtask

    // Field extremes, each mode, set ageing, and the low-confidence cases.
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        send_event(rirr_pkg::MODE_VICTIM, 11'd0, 4'd9, 16'h0000);
        send_event(rirr_pkg::MODE_VICTIM, 11'd2047, 4'd0, 16'hFFFF);
        send_event(rirr_pkg::MODE_FILL, 11'd2047, 4'd15, 16'hFFFF);
        send_event(rirr_pkg::MODE_FILL, 11'd2047, 4'd0, 16'h7FFF);
        send_event(rirr_pkg::MODE_HIT, 11'd2047, 4'd15, 16'h0000);
        send_event(rirr_pkg::MODE_HIT, 11'd2047, 4'd15, 16'hAAAA);
        send_event(rirr_pkg::MODE_FILL, 11'd2047, 4'd3, 16'hFFFF);
        send_event(rirr_pkg::MODE_NONE, 11'd2047, 4'd15, 16'hFFFF);
        // Bring every way of one set below the top so the victim search ages it.
        for (int w = 0; w < WAYS; w++)
        begin
            send_event(rirr_pkg::MODE_HIT, 11'd5, w[3:0], 16'h1234);
        end
        send_event(rirr_pkg::MODE_VICTIM, 11'd5, 4'd0, 16'h0);
        send_event(rirr_pkg::MODE_VICTIM, 11'd5, 4'd0, 16'h0);
        // Zero confidence threshold with a signature that has no samples.
        set_limits(32'd25000, 32'd50000, 16'd0);
        send_event(rirr_pkg::MODE_FILL, 11'd6, 4'd1, 16'h4321);
        send_event(rirr_pkg::MODE_FILL, 11'd6, 4'd2, 16'hFFFF);
    endtask

    // Mostly well-formed traffic on a few hot sets and signatures so that
    // fills, hits and evictions feed each other; the rest is wide noise.
    task automatic test_random(int count);
        rirr_pkg::mode_t mode;
        bit [10:0]       set_idx;
        bit [3:0]        way;
        bit [15:0]       pc;
        int              pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            mode = pick < 30 ? rirr_pkg::MODE_VICTIM : pick < 60 ? rirr_pkg::MODE_HIT :
                   pick < 96 ? rirr_pkg::MODE_FILL : rirr_pkg::MODE_NONE;
            if ($urandom_range(9) == 0)
            begin
                set_idx = 11'($urandom);
                pc = 16'($urandom);
            end
            else
            begin
                set_idx = 11'($urandom_range(3) * 512 + 7);
                pc = {1'($urandom_range(1)), 12'd0, 3'($urandom_range(7))};
            end
            way = 4'($urandom);
            send_event(mode, set_idx, way, pc);
        end
    endtask

    task automatic test_idle_phases(int count);
        send_idle_pct = 0;  stall_pct = 0;  test_random(count);
        send_idle_pct = 57; stall_pct = 0;  test_random(count);
        send_idle_pct = 0;  stall_pct = 57; test_random(count);
        send_idle_pct = 33; stall_pct = 33; test_random(count);
    endtask

    // Result side: random stall, sample at the falling edge, check at the
    // next rising edge where the beat is taken.
    logic       beat_seen = 1'b0;
    logic [4:0] beat_fields;
    logic [4:0] want;

    always @(negedge clk)
    begin
        beat_seen   <= m_tvalid && m_tready;
        beat_fields <= {m_tuser, m_tdata[3:0]};
    end

    always @(posedge clk)
    begin
        m_tready <= $urandom_range(99) >= stall_pct;
        if (beat_seen)
        begin
            if (victim_queue.size() == 0)
            begin
                $error("unexpected result beat: victim_way %0d victim_valid %0d",
                       beat_fields[3:0], beat_fields[4]);
                failed = 1'b1;
            end
            else
            begin
                want = victim_queue.pop_front();
                if (want[3:0] !== beat_fields[3:0])
                begin
                    $error("victim_way expected %0d actual %0d", want[3:0], beat_fields[3:0]);
                    failed = 1'b1;
                end
                if (want[4] !== beat_fields[4])
                begin
                    $error("victim_valid expected %0d actual %0d", want[4], beat_fields[4]);
                    failed = 1'b1;
                end
            end
        end
    end

    // Run limit; allows for the clearing pass after reset.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLE)
        begin
            $display("reuse_interval_rrip_replacement: mismatch");
            $finish;
        end
    end

    initial
    begin
        send_idle_pct = 0;
        stall_pct = 0;
        access_ctr = '0;
        short_limit = 32'd25000;
        moderate_limit = 32'd50000;
        conf_min = 16'd2;
        for (int i = 0; i < LINES; i++)
        begin
            age_mem[i] = 2'(AGE_TOP);
            reused_mem[i] = 1'b0;
            sig_mem[i] = '0;
            stamp_mem[i] = '0;
        end
        for (int i = 0; i < SIGS; i++)
        begin
            sum_mem[i] = '0;
            count_mem[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_limits(32'd4, 32'd40, 16'd1);
        test_idle_phases(50);
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
        test_idle_phases(25);
        set_limits(32'd0, 32'd0, 16'hFFFF);
        test_idle_phases(25);
        set_limits(32'd12, 32'd25, 16'd3);
        test_idle_phases(75);

        wait_idle();
        if (!failed)
        begin
            $display("reuse_interval_rrip_replacement: match");
        end
        else
        begin
            $display("reuse_interval_rrip_replacement: mismatch");
        end
        $finish;
    end

endmodule
